// ===== hdl/grid_astar_path_search_top_macros.svh =====
// Assertion helpers for the grid path search block.
`ifndef GRID_ASTAR_PATH_SEARCH_TOP_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define GAPS_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset.
`define GAPS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ===== hdl/gaps_pkg.sv =====
// ----------------------------------------------------------------------------
// gaps_pkg: shared definitions of the grid path search block
// Sizes, register indexes, direction codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package gaps_pkg;

  localparam int unsigned MaxRowsDef = 8;
  localparam int unsigned MaxColsDef = 8;
  localparam int unsigned CfgW       = 4;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CoordW     = 3;

  localparam logic [CfgIdxW-1:0] RegRows = 1'b0;
  localparam logic [CfgIdxW-1:0] RegCols = 1'b1;

  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirDown  = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StScan,
    StScanWait,
    StPick,
    StNbrRd,
    StNbrWr,
    StTrace,
    StTraceWait,
    StEmit,
    StNone
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/grid_astar_path_search_top.sv =====
// ----------------------------------------------------------------------------
// grid_astar_path_search_top: A* search on a small grid of blocked cells
// Cell writes, 4-neighbour Manhattan A* search, path streamed start first.
// ----------------------------------------------------------------------------
// A grid-write request updates the blocked map. A search request first sweeps
// the cell memory (one cell a cycle). Each expansion then scans every cell of
// the cell memory at one read a cycle to find the open cell of least f (ties
// to lowest index), and updates the four neighbours with one read and one
// write each. Tracing the path back reads each cell and stores it in the path
// memory, goal first, and each path cell leaves as one result; a path cell is
// not read while the read of the one before is still pending. No request is
// taken while a search runs or a result waits.
`default_nettype none

module grid_astar_path_search_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [gaps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [gaps_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // mode, cell_row, cell_col, blocked, start_row, start_col, goal_row, goal_col
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // path_row, path_col, found
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);

  localparam int unsigned MAX_ROWS = gaps_pkg::MaxRowsDef;
  localparam int unsigned MAX_COLS = gaps_pkg::MaxColsDef;
  localparam int unsigned NCells = MAX_ROWS * MAX_COLS;
  localparam int unsigned IdxW   = $clog2(NCells);
  localparam int unsigned RW     = $clog2(MAX_ROWS);
  localparam int unsigned CW     = $clog2(MAX_COLS);
  localparam int unsigned CntW   = $clog2(NCells + 1);
  localparam int unsigned GW     = CntW + 1;
  localparam int unsigned FW     = GW + 1;

  // cell memory entry: seen, open, closed, g, parent
  typedef struct packed {
    logic          seen;
    logic          open;
    logic          closed;
    logic [GW-1:0] g;
    logic [1:0]    par;
  } cell_t;

  gaps_pkg::state_e state_q, state_d;

  logic [gaps_pkg::CfgW-1:0] rows_q, cols_q;
  logic [gaps_pkg::CfgW-1:0] nr, nc;

  logic                 blk_mem [NCells];
  cell_t                cel_mem [NCells];
  logic [IdxW-1:0]      pth_mem [NCells];

  logic [2:0] gr_q, gc_q;
  logic [IdxW-1:0] start_q, goal_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            any_q, any_d;
  logic [IdxW-1:0] best_q, best_d;
  logic [FW-1:0]   bestf_q, bestf_d;
  logic [GW-1:0]   bestg_q, bestg_d;
  logic [1:0]      bestp_q, bestp_d;
  logic [IdxW-1:0] rdi_q, rdi_d;
  logic [2:0]      dir_q, dir_d;
  logic [CntW-1:0] len_q, len_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [CntW-1:0] ocnt_q, ocnt_d;

  cell_t           rd_q;
  logic            blk_q;
  logic [IdxW-1:0] prd_q;

  logic            cwe;
  logic [IdxW-1:0] cwa;
  cell_t           cwd;
  logic [IdxW-1:0] cra;
  logic            pwe;
  logic [IdxW-1:0] pwa, pra;

  logic            ovalid_q, olast_q, ofound_q;
  logic [2:0]      orow_q, ocol_q;
  logic            emit_go, emit_none;

  // path read data arrives in the cycle after the address; hold a pending flag
  logic pend_q;
  logic pend_last_q;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == gaps_pkg::StIdle) && !ovalid_q;

  assign nr = (rows_q > gaps_pkg::CfgW'(MAX_ROWS)) ? gaps_pkg::CfgW'(MAX_ROWS) : rows_q;
  assign nc = (cols_q > gaps_pkg::CfgW'(MAX_COLS)) ? gaps_pkg::CfgW'(MAX_COLS) : cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= gaps_pkg::CfgW'(8);
      cols_q <= gaps_pkg::CfgW'(8);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gaps_pkg::RegRows) rows_q <= cfg_data_i;
      else cols_q <= cfg_data_i;
    end
  end

  // cell index helpers
  function automatic logic [IdxW-1:0] mk(input logic [RW-1:0] r, input logic [CW-1:0] c);
    mk = IdxW'(r * MAX_COLS + c);
  endfunction

  logic [RW-1:0] br, cr_r;
  logic [CW-1:0] bc, cr_c;
  assign br = RW'(best_q / MAX_COLS);
  assign bc = CW'(best_q % MAX_COLS);
  assign cr_r = RW'(cur_q / MAX_COLS);
  assign cr_c = CW'(cur_q % MAX_COLS);

  // f (g plus Manhattan heuristic) of the cell read last cycle
  logic [RW-1:0] sr_row;
  logic [CW-1:0] sr_col;
  logic [IdxW-1:0] scan_i;
  logic [FW-1:0] hf;
  logic [RW:0] dr;
  logic [CW:0] dc;
  assign scan_i = rdi_q;
  assign sr_row = RW'(scan_i / MAX_COLS);
  assign sr_col = CW'(scan_i % MAX_COLS);
  always_comb begin
    dr = ({1'b0, sr_row} > (RW+1)'(gr_q)) ? ({1'b0, sr_row} - (RW+1)'(gr_q))
                                          : ((RW+1)'(gr_q) - {1'b0, sr_row});
    dc = ({1'b0, sr_col} > (CW+1)'(gc_q)) ? ({1'b0, sr_col} - (CW+1)'(gc_q))
                                          : ((CW+1)'(gc_q) - {1'b0, sr_col});
    hf = FW'(rd_q.g) + FW'(dr) + FW'(dc);
  end

  // neighbour candidate
  logic            nb_ok;
  logic [IdxW-1:0] nb_i;
  always_comb begin
    logic [RW:0] qr;
    logic [CW:0] qc;
    qr = {1'b0, br};
    qc = {1'b0, bc};
    nb_ok = 1'b1;
    unique case (dir_q[1:0])
      gaps_pkg::DirUp:   begin if (br == '0) nb_ok = 1'b0; qr = qr - 1'b1; end
      gaps_pkg::DirDown: qr = qr + 1'b1;
      gaps_pkg::DirLeft: begin if (bc == '0) nb_ok = 1'b0; qc = qc - 1'b1; end
      default:           qc = qc + 1'b1;
    endcase
    if ((CntW+1)'(qr) >= (CntW+1)'(nr) || (CntW+1)'(qc) >= (CntW+1)'(nc)) nb_ok = 1'b0;
    nb_i = mk(RW'(qr), CW'(qc));
  end

  // parent of the traced cell
  logic [IdxW-1:0] par_i;
  always_comb begin
    logic [RW:0] pr;
    logic [CW:0] pc;
    pr = {1'b0, cr_r};
    pc = {1'b0, cr_c};
    unique case (rd_q.par)
      gaps_pkg::DirUp:   pr = pr + 1'b1;
      gaps_pkg::DirDown: pr = pr - 1'b1;
      gaps_pkg::DirLeft: pc = pc + 1'b1;
      default:           pc = pc - 1'b1;
    endcase
    par_i = mk(RW'(pr), CW'(pc));
  end

  logic [GW-1:0] ng;
  assign ng = bestg_q + 1'b1;

  // blocked map reads as free until a cell is first written
  logic [NCells-1:0] bvld_q;
  logic              bv_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gaps_pkg::StIdle: if (acc && s_axis_tdata[0]) begin
        if ((gaps_pkg::CfgW)'(s_axis_tdata[10:8])  >= nr ||
            (gaps_pkg::CfgW)'(s_axis_tdata[13:11]) >= nc ||
            (gaps_pkg::CfgW)'(s_axis_tdata[16:14]) >= nr ||
            (gaps_pkg::CfgW)'(s_axis_tdata[19:17]) >= nc) state_d = gaps_pkg::StNone;
        else state_d = gaps_pkg::StClear;
      end
      gaps_pkg::StClear:    if (cnt_q == CntW'(NCells - 1)) state_d = gaps_pkg::StScan;
      gaps_pkg::StScan:     state_d = gaps_pkg::StScanWait;
      gaps_pkg::StScanWait: if (cnt_q == CntW'(NCells)) state_d = gaps_pkg::StPick;
      gaps_pkg::StPick: begin
        if (!any_q) state_d = gaps_pkg::StNone;
        else if (best_q == goal_q) state_d = gaps_pkg::StTrace;
        else state_d = gaps_pkg::StNbrRd;
      end
      gaps_pkg::StNbrRd:    state_d = gaps_pkg::StNbrWr;
      gaps_pkg::StNbrWr:    if (dir_q == 3'd3) state_d = gaps_pkg::StScan;
                            else state_d = gaps_pkg::StNbrRd;
      gaps_pkg::StTrace:    state_d = gaps_pkg::StTraceWait;
      gaps_pkg::StTraceWait: begin
        if (cur_q == start_q) state_d = gaps_pkg::StEmit;
        else state_d = gaps_pkg::StTrace;
      end
      gaps_pkg::StEmit: if (ocnt_q == '0 && !ovalid_q) state_d = gaps_pkg::StIdle;
      gaps_pkg::StNone: if (!ovalid_q) state_d = gaps_pkg::StIdle;
      default: state_d = gaps_pkg::StIdle;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_d = cnt_q; any_d = any_q; best_d = best_q; bestf_d = bestf_q;
    bestg_d = bestg_q; bestp_d = bestp_q; rdi_d = rdi_q; dir_d = dir_q; len_d = len_q;
    cur_d = cur_q; ocnt_d = ocnt_q;
    cwe = 1'b0; cwa = rdi_q; cwd = rd_q; cra = rdi_q;
    pwe = 1'b0; pwa = len_q[IdxW-1:0]; pra = ocnt_q[IdxW-1:0] - 1'b1;
    emit_go = 1'b0; emit_none = 1'b0;
    unique case (state_q)
      gaps_pkg::StIdle: if (acc && s_axis_tdata[0]) begin
        cnt_d = '0;
      end
      gaps_pkg::StClear: begin
        cwe = 1'b1;
        cwa = cnt_q[IdxW-1:0];
        cwd = '0;
        if (cnt_q[IdxW-1:0] == start_q) begin
          cwd.seen = 1'b1;
          cwd.open = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(NCells - 1)) cnt_d = '0;
      end
      gaps_pkg::StScan: begin
        any_d = 1'b0; rdi_d = '0; cra = '0; cnt_d = '0;
      end
      gaps_pkg::StScanWait: begin
        if (rd_q.open && (!any_q || hf < bestf_q)) begin
          any_d = 1'b1; best_d = rdi_q; bestf_d = hf; bestg_d = rd_q.g;
          bestp_d = rd_q.par;
        end
        cnt_d = cnt_q + 1'b1;
        rdi_d = rdi_q + 1'b1;
        cra = rdi_q + 1'b1;
        dir_d = '0;
      end
      gaps_pkg::StPick: begin
        if (any_q && best_q != goal_q) begin
          cwe = 1'b1; cwa = best_q;
          cwd = '0; cwd.seen = 1'b1; cwd.closed = 1'b1; cwd.g = bestg_q;
          cwd.par = bestp_q;
        end
        cur_d = goal_q; len_d = '0;
        cra = nb_i;
      end
      gaps_pkg::StNbrRd: cra = nb_i;
      gaps_pkg::StNbrWr: begin
        if (nb_ok && !(blk_q && bv_q) && !rd_q.closed && (!rd_q.seen || ng < rd_q.g)) begin
          cwe = 1'b1; cwa = nb_i;
          cwd.seen = 1'b1; cwd.open = 1'b1; cwd.closed = 1'b0;
          cwd.g = ng; cwd.par = dir_q[1:0];
        end
        dir_d = dir_q + 1'b1;
      end
      gaps_pkg::StTrace: cra = cur_q;
      gaps_pkg::StTraceWait: begin
        pwe = 1'b1; pwa = len_q[IdxW-1:0];
        len_d = len_q + 1'b1;
        cur_d = par_i;
        if (cur_q == start_q) ocnt_d = len_q + 1'b1;
      end
      gaps_pkg::StEmit: begin
        pra = ocnt_q[IdxW-1:0] - 1'b1;
        if (ocnt_q != '0 && !pend_q && (!ovalid_q || m_axis_tready)) begin
          emit_go = 1'b1;
          ocnt_d = ocnt_q - 1'b1;
        end
      end
      gaps_pkg::StNone: emit_none = !ovalid_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gaps_pkg::StIdle;
      ovalid_q <= 1'b0;
      pend_q <= 1'b0;
      cnt_q <= '0; any_q <= 1'b0; ocnt_q <= '0; dir_q <= '0; len_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; any_q <= any_d; ocnt_q <= ocnt_d; dir_q <= dir_d; len_q <= len_d;
      pend_q <= emit_go;
      ovalid_q <= pend_q || emit_none || (ovalid_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d; bestf_q <= bestf_d; bestg_q <= bestg_d; bestp_q <= bestp_d;
    rdi_q <= rdi_d; cur_q <= cur_d;
    pend_last_q <= (ocnt_q == CntW'(1));
    if (state_q == gaps_pkg::StIdle && acc) begin
      gr_q <= s_axis_tdata[16:14]; gc_q <= s_axis_tdata[19:17];
      start_q <= mk(RW'(s_axis_tdata[10:8]), CW'(s_axis_tdata[13:11]));
      goal_q  <= mk(RW'(s_axis_tdata[16:14]), CW'(s_axis_tdata[19:17]));
    end
    if (pend_q) begin
      orow_q <= 3'(prd_q / MAX_COLS);
      ocol_q <= 3'(prd_q % MAX_COLS);
      ofound_q <= 1'b1;
      olast_q <= pend_last_q;
    end else if (emit_none) begin
      orow_q <= '0; ocol_q <= '0; ofound_q <= 1'b0; olast_q <= 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (acc && !s_axis_tdata[0] &&
        (CntW+1)'(s_axis_tdata[3:1]) < (CntW+1)'(MAX_ROWS) &&
        (CntW+1)'(s_axis_tdata[6:4]) < (CntW+1)'(MAX_COLS))
      blk_mem[mk(RW'(s_axis_tdata[3:1]), CW'(s_axis_tdata[6:4]))] <= s_axis_tdata[7];
    blk_q <= blk_mem[cra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bvld_q <= '0;
    else if (acc && !s_axis_tdata[0] &&
             (CntW+1)'(s_axis_tdata[3:1]) < (CntW+1)'(MAX_ROWS) &&
             (CntW+1)'(s_axis_tdata[6:4]) < (CntW+1)'(MAX_COLS))
      bvld_q[mk(RW'(s_axis_tdata[3:1]), CW'(s_axis_tdata[6:4]))] <= 1'b1;
  end
  always_ff @(posedge clk_i) bv_q <= bvld_q[cra];

  always_ff @(posedge clk_i) begin
    if (cwe) cel_mem[cwa] <= cwd;
    rd_q <= cel_mem[cra];
  end

  always_ff @(posedge clk_i) begin
    if (pwe) pth_mem[pwa] <= cur_q;
    prd_q <= pth_mem[pra];
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, ofound_q, ocol_q, orow_q};
  assign m_axis_tlast  = olast_q;

endmodule

`default_nettype wire

// ===== hdl/gaps_checker.sv =====
// ----------------------------------------------------------------------------
// gaps_checker: port-level checks of the grid path search block
// Output stability, no new request taken while a result waits, the no-path form and the pad bit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_astar_path_search_top_macros.svh"

module gaps_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  `GAPS_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result dropped")
  `GAPS_ASSERT_IMP(a_busy, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready,
    "request taken while result waits")
  `GAPS_ASSERT_IMP(a_nf, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[6],
    m_axis_tlast && m_axis_tdata[5:0] == 6'd0, "bad no-path result")
  `GAPS_ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[7] == 1'b0,
    "pad bit set")

  logic unused;
  assign unused = s_axis_tvalid;

endmodule

bind grid_astar_path_search_top gaps_checker u_gaps_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

`default_nettype wire

// ===== tb/sv/grid_path_checker.sv =====
// ----------------------------------------------------------------------------
// grid_path_checker: path predictor and result checker of the grid search
// Watches the config port and both streams, runs its own A* over a copy of
// the grid and compares every result against the oldest expected path cell.
// ----------------------------------------------------------------------------
module grid_path_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [gaps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gaps_pkg::CfgW-1:0]    cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       last;
    logic       found;
    logic [2:0] col;
    logic [2:0] row;
  } path_cell_t;

  logic [3:0] rows_q = 4'd8;
  logic [3:0] cols_q = 4'd8;
  logic       obstacle [64];
  path_cell_t path_q [$];
  int         fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = path_q.size();

  initial foreach (obstacle[i]) obstacle[i] = 1'b0;

  function automatic int gap(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  task automatic push_no_path();
    path_q.insert(path_q.size(),
                  path_cell_t'{last: 1'b1, found: 1'b0, col: 3'd0, row: 3'd0});
  endtask

  task automatic predict_path(int sr, int sc, int gr, int gc);
    int nr, nc, start, goal, best, bestf, f, r, c, qr, qc, q, g, len, cur;
    bit any;
    bit seen [64];
    bit open_c [64];
    bit done_c [64];
    int cost [64];
    logic [1:0] dir [64];
    int trail [64];
    nr = rows_q > 8 ? 8 : rows_q;
    nc = cols_q > 8 ? 8 : cols_q;
    if (sr >= nr || sc >= nc || gr >= nr || gc >= nc) begin
      push_no_path();
      return;
    end
    foreach (seen[i]) begin
      seen[i] = 0; open_c[i] = 0; done_c[i] = 0; cost[i] = 0; dir[i] = gaps_pkg::DirUp;
    end
    start = sr * 8 + sc;
    goal  = gr * 8 + gc;
    seen[start] = 1;
    open_c[start] = 1;
    forever begin
      any = 0; best = 0; bestf = 0;
      for (int i = 0; i < 64; i++) begin
        if (!open_c[i]) continue;
        f = cost[i] + gap(i / 8, gr) + gap(i % 8, gc);
        if (!any || f < bestf) begin
          any = 1; best = i; bestf = f;
        end
      end
      if (!any) begin
        push_no_path();
        return;
      end
      if (best == goal) break;
      open_c[best] = 0;
      done_c[best] = 1;
      r = best / 8;
      c = best % 8;
      for (int d = 0; d < 4; d++) begin
        qr = r; qc = c;
        if (d == gaps_pkg::DirUp) begin
          if (r == 0) continue;
          qr = r - 1;
        end else if (d == gaps_pkg::DirDown) qr = r + 1;
        else if (d == gaps_pkg::DirLeft) begin
          if (c == 0) continue;
          qc = c - 1;
        end else qc = c + 1;
        if (qr >= nr || qc >= nc) continue;
        q = qr * 8 + qc;
        if (obstacle[q] || done_c[q]) continue;
        g = cost[best] + 1;
        if (!seen[q] || g < cost[q]) begin
          seen[q] = 1; open_c[q] = 1; cost[q] = g; dir[q] = 2'(d);
        end
      end
    end
    len = 0;
    cur = goal;
    forever begin
      trail[len++] = cur;
      if (cur == start) break;
      r = cur / 8;
      c = cur % 8;
      case (dir[cur])
        gaps_pkg::DirUp:   r = r + 1;
        gaps_pkg::DirDown: r = r - 1;
        gaps_pkg::DirLeft: c = c + 1;
        default:           c = c - 1;
      endcase
      cur = r * 8 + c;
    end
    for (int i = 0; i < len; i++) begin
      cur = trail[len - 1 - i];
      path_q.insert(path_q.size(),
                    path_cell_t'{last: (i + 1 == len), found: 1'b1,
                                 col: 3'(cur % 8), row: 3'(cur / 8)});
    end
  endtask

  always @(posedge clk_i) begin
    path_cell_t exp_c;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == gaps_pkg::RegRows) rows_q <= cfg_data_i;
        else cols_q <= cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (!s_axis_tdata[0])
          obstacle[s_axis_tdata[3:1] * 8 + s_axis_tdata[6:4]] = s_axis_tdata[7];
        else
          predict_path(s_axis_tdata[10:8], s_axis_tdata[13:11],
                       s_axis_tdata[16:14], s_axis_tdata[19:17]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (path_q.size() == 0) begin
          $error("unexpected result row=%0d col=%0d", m_axis_tdata[2:0],
                 m_axis_tdata[5:3]);
          fails++;
        end else begin
          exp_c = path_q.pop_front();
          if (m_axis_tdata[2:0] !== exp_c.row) begin
            $error("path_row expected %0d got %0d", exp_c.row, m_axis_tdata[2:0]);
            fails++;
          end
          if (m_axis_tdata[5:3] !== exp_c.col) begin
            $error("path_col expected %0d got %0d", exp_c.col, m_axis_tdata[5:3]);
            fails++;
          end
          if (m_axis_tdata[6] !== exp_c.found) begin
            $error("found expected %0d got %0d", exp_c.found, m_axis_tdata[6]);
            fails++;
          end
          if (m_axis_tlast !== exp_c.last) begin
            $error("last expected %0d got %0d", exp_c.last, m_axis_tlast);
            fails++;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the grid A* path search block
// Loads obstacle maps, runs directed and random searches over several grid
// sizes with random stalls on both streams; a checker predicts each path.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [gaps_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [gaps_pkg::CfgW-1:0]    cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;
  bit          calm = 0;

  always #5 clk_i = ~clk_i;

  grid_astar_path_search_top dut (.*);

  grid_path_checker checker_i (.*, .fail_count_o(fail_count), .pending_o(pending));

  // result-side stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // tvalid stays high after a request until the next request or an idle gap
  task automatic send(logic [23:0] word);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [23:0] cell_wr(int r, int c, bit blk);
    return {16'd0, blk, 3'(c), 3'(r), 1'b0};
  endfunction

  function automatic logic [23:0] search_req(int sr, int sc, int gr, int gc);
    return {4'd0, 3'(gc), 3'(gr), 3'(sc), 3'(sr), 8'd0 | 8'(1)} |
           {4'd0, 12'd0, 8'($urandom) & 8'hFE};
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_size(int rows, int cols);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= gaps_pkg::RegRows; cfg_data_i <= 4'(rows);
    @(posedge clk_i);
    cfg_idx_i <= gaps_pkg::RegCols; cfg_data_i <= 4'(cols);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int n, int rows, int cols);
    int lim_r, lim_c;
    set_size(rows, cols);
    lim_r = rows > 8 ? 7 : (rows == 0 ? 0 : rows - 1);
    lim_c = cols > 8 ? 7 : (cols == 0 ? 0 : cols - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0)
        send(cell_wr($urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom_range(0, 3) == 0));
      else if ($urandom_range(0, 9) == 0)
        send(search_req($urandom_range(0, 7), $urandom_range(0, 7),
                        $urandom_range(0, 7), $urandom_range(0, 7)));
      else
        send(search_req($urandom_range(0, lim_r), $urandom_range(0, lim_c),
                        $urandom_range(0, lim_r), $urandom_range(0, lim_c)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: corners, same cell, blocked start/goal, walls, outside region
    send(search_req(0, 0, 7, 7));
    send(search_req(7, 7, 0, 0));
    send(search_req(3, 4, 3, 4));
    send(cell_wr(3, 4, 1));
    send(search_req(3, 4, 3, 4));
    send(search_req(3, 4, 0, 0));
    send(search_req(0, 0, 3, 4));
    for (int r = 0; r < 7; r++) send(cell_wr(r, 5, 1));
    send(search_req(0, 0, 0, 7));
    send(cell_wr(7, 5, 1));
    send(search_req(0, 0, 0, 7));
    send(cell_wr(7, 5, 0));
    send(cell_wr(3, 4, 0));
    set_size(4, 3);
    send(search_req(0, 0, 3, 2));
    send(search_req(0, 0, 4, 2));
    set_size(1, 1);
    send(search_req(0, 0, 0, 0));
    set_size(0, 15);
    send(search_req(0, 0, 0, 0));
    random_phase(60, 8, 8);
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++) send(cell_wr(r, c, 0));
    random_phase(60, 15, 12);
    random_phase(50, 3, 8);
    random_phase(40, 8, 2);
    random_phase(50, 6, 5);
    calm = 1;
    random_phase(40, 8, 8);
    drain();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/gaps_pkg.sv
hdl/grid_astar_path_search_top.sv
hdl/gaps_checker.sv
tb/sv/grid_path_checker.sv
tb/sv/tb.sv
